@@ src/pid_controller_step_assert.svh @@
// Assertion macros for the PID step controller.
// Included by pid_controller_step.sv, which carries concurrent checks; depends on nothing else.
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define PCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pid_controller_step: assertion failed");

// Checks that a condition in one cycle leads to a consequence in the next.
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pid_controller_step: assertion failed");

`else

`define PCS_ASSERT(lbl, clk, rst, prop)
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/pcs_pkg.sv @@
// Shared types, register indexes and saturating helpers of the PID step controller.
// Used by every module of the block; depends on nothing.
package pcs_pkg;

   typedef logic signed [31:0] word_type;

   localparam logic [2:0] CSR_KP               = 3'd0;
   localparam logic [2:0] CSR_KI_DT            = 3'd1;
   localparam logic [2:0] CSR_KD_DT            = 3'd2;
   localparam logic [2:0] CSR_INTEGRAL_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_DERIVATIVE_LIMIT = 3'd4;
   localparam logic [2:0] CSR_OUT_MAX          = 3'd5;
   localparam logic [2:0] CSR_OUT_MIN          = 3'd6;

   localparam logic FUNC_STEP    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam logic signed [33:0] S32_MAX_W = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] S32_MIN_W = 34'sh3_8000_0000;

   typedef struct packed {
      word_type    kp;
      word_type    ki_dt;
      word_type    kd_dt;
      logic [30:0] integral_limit;
      logic [30:0] derivative_limit;
      word_type    out_max;
      word_type    out_min;
   } cfg_type;

   // Scaled products of one control request.
   typedef struct packed {
      logic     first;
      word_type p;
      word_type ip;
      word_type dp;
   } prod_type;

   // Proportional term, updated integral and clamped derivative.
   typedef struct packed {
      word_type p;
      word_type acc;
      word_type d;
   } integ_type;

   function automatic logic signed [33:0] ext34(input word_type v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic word_type sat32(input logic signed [33:0] v);
      word_type r;
      if (v > S32_MAX_W) begin
         r = S32_MAX_W[31:0];
      end else if (v < S32_MIN_W) begin
         r = S32_MIN_W[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // With crossed bounds, a value below lo gives lo and any other gives hi.
   function automatic word_type limit(input word_type v, input word_type lo,
                                      input word_type hi);
      word_type r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ src/pid_controller_step.sv @@
// PID step controller on signed fixed point with FRAC_BITS fraction bits. A step
// request carries an error sample and yields one drive value; a restart request re-arms
// first-step handling and yields no response. The block accepts one request per cycle
// unless the response stalls: the products, the integral update and the output clamp
// each sit in their own register stage, and the integral accumulator loop closes within
// the third stage. Each stage holds its item while the response is not taken, so
// requests are refused only when all four stages are full. The user must write registers
// through the csr_ port while no request is in flight; the block does not enforce it.
`include "pid_controller_step_assert.svh"

module pid_controller_step #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_error_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_out,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   pcs_pkg::cfg_type   cfg_ff;
   pcs_pkg::cfg_type   cfg_in;

   logic               first_step_ff;
   pcs_pkg::word_type  last_error_ff;

   logic               s0_valid_ff;
   pcs_pkg::word_type  s0_e_ff;
   pcs_pkg::word_type  s0_diff_ff;
   logic               s0_first_ff;
   pcs_pkg::word_type  diff_in;

   logic               s1_valid_ff;
   pcs_pkg::prod_type  s1_ff;
   pcs_pkg::prod_type  prod_in;

   logic               s2_valid;
   logic               s2_ready;
   pcs_pkg::integ_type s2_data;

   logic               rsp_valid_ff;
   pcs_pkg::word_type  drive_ff;
   pcs_pkg::word_type  pi_sum;
   pcs_pkg::word_type  drive_in;

   logic               s1_ready;
   logic               s3_ready;
   logic               take;
   logic               is_step;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pcs_pkg::CSR_KP:               cfg_in.kp               = csr_wdata;
            pcs_pkg::CSR_KI_DT:            cfg_in.ki_dt            = csr_wdata;
            pcs_pkg::CSR_KD_DT:            cfg_in.kd_dt            = csr_wdata;
            pcs_pkg::CSR_INTEGRAL_LIMIT:   cfg_in.integral_limit   = csr_wdata[30:0];
            pcs_pkg::CSR_DERIVATIVE_LIMIT: cfg_in.derivative_limit = csr_wdata[30:0];
            pcs_pkg::CSR_OUT_MAX:          cfg_in.out_max          = csr_wdata;
            pcs_pkg::CSR_OUT_MIN:          cfg_in.out_min          = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage ready chain: each stage loads when empty or when its item moves on.
   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = !s0_valid_ff || s1_ready;
   assign take      = req_valid && req_ready;
   assign is_step   = req_func == pcs_pkg::FUNC_STEP;

   // Input stage. The error change is taken against the previous step's sample.
   assign diff_in = pcs_pkg::sat32(pcs_pkg::ext34(req_error_in)
                                   - pcs_pkg::ext34(last_error_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         first_step_ff <= 1'b1;
         last_error_ff <= '0;
      end else begin
         if (req_ready) begin
            s0_valid_ff <= take && is_step;
         end
         if (take) begin
            if (is_step) begin
               first_step_ff <= 1'b0;
               last_error_ff <= req_error_in;
            end else begin
               first_step_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && is_step) begin
         s0_e_ff     <= req_error_in;
         s0_diff_ff  <= diff_in;
         s0_first_ff <= first_step_ff;
      end
   end

   // Product stage.
   pcs_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p (
      .a (cfg_ff.kp),
      .b (s0_e_ff),
      .y (prod_in.p)
   );

   pcs_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_i (
      .a (s0_e_ff),
      .b (cfg_ff.ki_dt),
      .y (prod_in.ip)
   );

   pcs_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_d (
      .a (cfg_ff.kd_dt),
      .b (s0_diff_ff),
      .y (prod_in.dp)
   );

   assign prod_in.first = s0_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s0_valid_ff) begin
         s1_ff <= prod_in;
      end
   end

   // Integral stage.
   pcs_integrator u_integrator (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid_ff),
      .in_ready  (s2_ready),
      .in_data   (s1_ff),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_data  (s2_data)
   );

   // Output stage.
   assign pi_sum   = pcs_pkg::sat32(pcs_pkg::ext34(s2_data.p) + pcs_pkg::ext34(s2_data.acc));
   assign drive_in = pcs_pkg::limit(
                        pcs_pkg::sat32(pcs_pkg::ext34(pi_sum) + pcs_pkg::ext34(s2_data.d)),
                        cfg_ff.out_min, cfg_ff.out_max);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = drive_ff;

   `PCS_ASSERT(a_refuse_only_when_full, clock, reset,
      !req_ready |-> (s0_valid_ff && s1_valid_ff && s2_valid && rsp_valid_ff && !rsp_ready))
   `PCS_ASSERT_NEXT(a_restart_no_item, clock, reset,
      take && (req_func == pcs_pkg::FUNC_RESTART), !s0_valid_ff && first_step_ff)
   `PCS_ASSERT_NEXT(a_step_updates_state, clock, reset,
      take && is_step, !first_step_ff && (last_error_ff == $past(req_error_in)))
   `PCS_ASSERT_NEXT(a_stall_keeps_integral_item, clock, reset,
      rsp_valid_ff && !rsp_ready && s2_valid, s2_valid)

endmodule

@@ src/pcs_fxmul.sv @@
// Signed fixed point multiplier: full product, floor shift by the fraction width,
// saturation to 32 bits. Depends on pcs_pkg.
module pcs_fxmul #(
   parameter int FRAC_BITS = 16
) (
   input  pcs_pkg::word_type a,
   input  pcs_pkg::word_type b,
   output pcs_pkg::word_type y
);

   localparam logic signed [63:0] MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] MIN64 = -64'sd2147483648;

   logic signed [63:0] prod;
   logic signed [63:0] shifted;

   assign prod    = a * b;
   // An arithmetic shift rounds toward minus infinity.
   assign shifted = prod >>> FRAC_BITS;

   always_comb begin
      if (shifted > MAX64) begin
         y = MAX64[31:0];
      end else if (shifted < MIN64) begin
         y = MIN64[31:0];
      end else begin
         y = shifted[31:0];
      end
   end

endmodule

@@ src/pcs_integrator.sv @@
// Integral stage of the PID step controller: accumulator update, limit, first-step
// reset and anti-windup, plus the derivative clamp. Depends on pcs_pkg.
module pcs_integrator (
   input  logic                clock,
   input  logic                reset,
   input  pcs_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  pcs_pkg::prod_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pcs_pkg::integ_type  out_data
);

   pcs_pkg::word_type  acc_ff;
   pcs_pkg::word_type  acc_in;
   logic               valid_ff;
   pcs_pkg::integ_type data_ff;
   pcs_pkg::integ_type data_in;

   pcs_pkg::word_type  sum_sat;
   pcs_pkg::word_type  lim_pos;
   pcs_pkg::word_type  lim_neg;
   pcs_pkg::word_type  acc_lim;
   pcs_pkg::word_type  acc_first;
   pcs_pkg::word_type  acc_hi;
   pcs_pkg::word_type  sum_hi;
   pcs_pkg::word_type  sum_lo;
   pcs_pkg::word_type  dlim_pos;
   logic signed [33:0] hi_gap;
   logic signed [33:0] lo_gap;
   logic               aw_en;
   logic               take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      sum_sat   = pcs_pkg::sat32(pcs_pkg::ext34(acc_ff) + pcs_pkg::ext34(in_data.ip));
      lim_pos   = {1'b0, cfg.integral_limit};
      lim_neg   = -lim_pos;
      acc_lim   = pcs_pkg::limit(sum_sat, lim_neg, lim_pos);
      acc_first = in_data.first ? '0 : acc_lim;

      // Anti-windup checks the saturated P+I against the upper bound, then checks
      // the possibly adjusted sum against the lower bound.
      hi_gap = pcs_pkg::ext34(cfg.out_max) - pcs_pkg::ext34(in_data.p);
      lo_gap = pcs_pkg::ext34(cfg.out_min) - pcs_pkg::ext34(in_data.p);
      aw_en  = cfg.out_max != cfg.out_min;

      sum_hi = pcs_pkg::sat32(pcs_pkg::ext34(in_data.p) + pcs_pkg::ext34(acc_first));
      acc_hi = (aw_en && (sum_hi > cfg.out_max)) ? pcs_pkg::sat32(hi_gap) : acc_first;
      sum_lo = pcs_pkg::sat32(pcs_pkg::ext34(in_data.p) + pcs_pkg::ext34(acc_hi));
      acc_in = (aw_en && (sum_lo < cfg.out_min)) ? pcs_pkg::sat32(lo_gap) : acc_hi;

      dlim_pos     = {1'b0, cfg.derivative_limit};
      data_in.p    = in_data.p;
      data_in.acc  = acc_in;
      data_in.d    = in_data.first ? '0 : pcs_pkg::limit(in_data.dp, -dlim_pos, dlim_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule
